// ===== rtl/sfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types and constants of the sniffer frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

    // number of frame start bytes and their reset value ("SNIF")
    localparam int          MAGIC_BYTES = 4;
    localparam logic [31:0] MAGIC_RESET = 32'h534E4946;

    // result queue, depth must be a power of two and at least two
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    // bit positions of the type byte
    localparam int FL_CRC   = 0;
    localparam int FL_CRCOK = 1;
    localparam int FL_RSSI  = 2;
    localparam int FL_LQI   = 3;
    localparam int FL_STAMP = 4;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_TYPE  = 4'd1,
        PH_LEN   = 4'd2,
        PH_DATA  = 4'd3,
        PH_CRC   = 4'd4,
        PH_CRCOK = 4'd5,
        PH_RSSI  = 4'd6,
        PH_LQI   = 4'd7,
        PH_STAMP = 4'd8
    } t_phase;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_END     = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_length;
        logic        accepted;
        logic [15:0] crc_value;
        logic [7:0]  crc_status;
        logic [7:0]  rssi;
        logic [7:0]  lqi;
        logic [15:0] timestamp;
        logic [7:0]  field_flags;
        logic        last;
    } t_result;

endpackage

// ===== rtl/sniffer_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sniffer_frame_parser
// deframes the sniffer serial format: emits a record per payload byte and
// one end-of-frame record with the trailer fields
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  input    | i_in_valid / o_in_ready    | i_rx_byte
//  output   | o_out_valid / i_out_ready  | o_kind .. o_last (12 fields)
//  config   | i_cfg_we (no wait)         | i_cfg_wdata (start bytes)
//
//  one input beat per cycle while the result queue has room; a byte is
//    registered, stepped through the frame logic and its records land in a
//    four-deep result queue, whose head record is offered on the output
//  a byte makes zero, one or two records; the last payload byte of a frame
//    with no trailer makes two, drained one per cycle while i_out_ready is high
//  input stalls only while the result queue has fewer than two free entries
//  synchronous active-low reset empties the queue, returns the frame logic
//    to the start byte search and the start bytes to "SNIF"
// ----------------------------------------------------------------------------
module sniffer_frame_parser #(
    parameter int MAGIC_BYTES = sfp_pkg::MAGIC_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // record output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_byte_index,
    output logic [7:0]  o_frame_length,
    output logic        o_accepted,
    output logic [15:0] o_crc_value,
    output logic [7:0]  o_crc_status,
    output logic [7:0]  o_rssi,
    output logic [7:0]  o_lqi,
    output logic [15:0] o_timestamp,
    output logic [7:0]  o_field_flags,
    output logic        o_last
);

    // start byte register
    logic [31:0] r_magic;

    // input stage
    logic        r_in_vld;
    logic [7:0]  r_in_byte;

    logic             w_room;
    logic             w_step;
    sfp_pkg::t_result w_res0;
    sfp_pkg::t_result w_res1;
    logic [1:0]       w_cnt;
    logic [1:0]       w_push_cnt;
    sfp_pkg::t_result w_head;

    // a held byte steps only when the queue can take both possible records
    assign w_step     = r_in_vld && w_room;
    assign o_in_ready = !r_in_vld || w_room;
    assign w_push_cnt = w_step ? w_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= sfp_pkg::MAGIC_RESET;
        end else if (i_cfg_we) begin
            r_magic <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    // byte register needs no reset, guarded by r_in_vld
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfp_deframer #(
        .MAGIC_BYTES (MAGIC_BYTES)
    ) u_deframer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_magic (r_magic),
        .o_res0  (w_res0),
        .o_res1  (w_res1),
        .o_cnt   (w_cnt)
    );

    sfp_rqueue u_rqueue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_d0       (w_res0),
        .i_d1       (w_res1),
        .i_push_cnt (w_push_cnt),
        .i_pop      (i_out_ready),
        .o_head     (w_head),
        .o_valid    (o_out_valid),
        .o_room     (w_room)
    );

    // unpack the head record onto the output ports
    assign o_kind         = w_head.kind;
    assign o_data_byte    = w_head.data_byte;
    assign o_byte_index   = w_head.byte_index;
    assign o_frame_length = w_head.frame_length;
    assign o_accepted     = w_head.accepted;
    assign o_crc_value    = w_head.crc_value;
    assign o_crc_status   = w_head.crc_status;
    assign o_rssi         = w_head.rssi;
    assign o_lqi          = w_head.lqi;
    assign o_timestamp    = w_head.timestamp;
    assign o_field_flags  = w_head.field_flags;
    assign o_last         = w_head.last;

    // a held byte that cannot step keeps the input stalled
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_room) |-> !o_in_ready)
        else $error("input taken while a byte is held");

    // a byte that stepped without a new one behind it leaves the stage empty
    a_stage_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !i_in_valid) |=> !r_in_vld)
        else $error("input stage kept a stepped byte");

endmodule

// ===== rtl/sfp_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_deframer
// frame state and one-byte step: yields up to two result records per byte
// ----------------------------------------------------------------------------
module sfp_deframer #(
    parameter int MAGIC_BYTES = sfp_pkg::MAGIC_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic [31:0]      i_magic,
    output sfp_pkg::t_result o_res0,
    output sfp_pkg::t_result o_res1,
    output logic [1:0]       o_cnt
);

    sfp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_pos,   n_pos;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_len,   n_len;
    logic [15:0] r_crc,   n_crc;
    logic [7:0]  r_crcok, n_crcok;
    logic [7:0]  r_rssi,  n_rssi;
    logic [7:0]  r_lqi,   n_lqi;
    logic [15:0] r_stamp, n_stamp;

    logic [1:0]  w_midx;
    logic [7:0]  w_expect;
    logic [15:0] w_lane;
    logic        w_pay_hit;
    logic        w_end_hit;
    sfp_pkg::t_result w_pay;
    sfp_pkg::t_result w_end;

    // start byte i sits at bits [31-8i : 24-8i]
    assign w_midx   = r_pos[1:0];
    assign w_expect = i_magic[{2'd3 - w_midx, 3'b000} +: 8];
    // byte placed in the low or high half of a little-endian word
    assign w_lane   = r_pos[0] ? {i_byte, 8'h00} : {8'h00, i_byte};

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_flags   = r_flags;
        n_len     = r_len;
        n_crc     = r_crc;
        n_crcok   = r_crcok;
        n_rssi    = r_rssi;
        n_lqi     = r_lqi;
        n_stamp   = r_stamp;
        w_pay_hit = 1'b0;
        w_end_hit = 1'b0;

        // consume the byte
        case (r_phase)
            sfp_pkg::PH_MAGIC: begin
                if (i_byte != w_expect) begin
                    n_pos = '0;
                end else if (r_pos == 8'(MAGIC_BYTES - 1)) begin
                    n_phase = sfp_pkg::PH_TYPE;
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + 8'd1;
                end
            end
            sfp_pkg::PH_TYPE: begin
                n_flags = i_byte;
                n_phase = sfp_pkg::PH_LEN;
            end
            sfp_pkg::PH_LEN: begin
                n_len   = i_byte;
                n_phase = sfp_pkg::PH_DATA;
                n_pos   = '0;
            end
            sfp_pkg::PH_DATA: begin
                w_pay_hit = 1'b1;
                n_pos     = r_pos + 8'd1;
            end
            sfp_pkg::PH_CRC: begin
                n_crc = r_crc | w_lane;
                n_pos = r_pos + 8'd1;
                if (n_pos >= 8'd2) begin
                    n_phase = sfp_pkg::PH_CRCOK;
                    n_pos   = '0;
                end
            end
            sfp_pkg::PH_CRCOK: begin
                n_crcok = i_byte;
                n_phase = sfp_pkg::PH_RSSI;
            end
            sfp_pkg::PH_RSSI: begin
                n_rssi  = i_byte;
                n_phase = sfp_pkg::PH_LQI;
            end
            sfp_pkg::PH_LQI: begin
                n_lqi   = i_byte;
                n_phase = sfp_pkg::PH_STAMP;
                n_pos   = '0;
                if (r_flags[sfp_pkg::FL_STAMP]) begin
                    n_stamp = '0;
                end
            end
            sfp_pkg::PH_STAMP: begin
                n_stamp = r_stamp | w_lane;
                n_pos   = r_pos + 8'd1;
            end
            default: begin
                n_phase = sfp_pkg::PH_MAGIC;
                n_pos   = '0;
            end
        endcase

        // skip trailer fields that are absent, in frame order
        if (n_phase == sfp_pkg::PH_DATA && n_pos >= n_len) begin
            n_phase = sfp_pkg::PH_CRC;
            n_pos   = '0;
            if (n_flags[sfp_pkg::FL_CRC]) begin
                n_crc = '0;
            end
        end
        if (n_phase == sfp_pkg::PH_CRC && !n_flags[sfp_pkg::FL_CRC]) begin
            n_phase = sfp_pkg::PH_CRCOK;
        end
        if (n_phase == sfp_pkg::PH_CRCOK && !n_flags[sfp_pkg::FL_CRCOK]) begin
            n_crcok = 8'd1;
            n_phase = sfp_pkg::PH_RSSI;
        end
        if (n_phase == sfp_pkg::PH_RSSI && !n_flags[sfp_pkg::FL_RSSI]) begin
            n_phase = sfp_pkg::PH_LQI;
        end
        if (n_phase == sfp_pkg::PH_LQI && !n_flags[sfp_pkg::FL_LQI]) begin
            n_phase = sfp_pkg::PH_STAMP;
            n_pos   = '0;
            if (n_flags[sfp_pkg::FL_STAMP]) begin
                n_stamp = '0;
            end
        end
        if (n_phase == sfp_pkg::PH_STAMP &&
            (!n_flags[sfp_pkg::FL_STAMP] || n_pos >= 8'd2)) begin
            w_end_hit = 1'b1;
            n_phase   = sfp_pkg::PH_MAGIC;
            n_pos     = '0;
        end
    end

    // payload record from the state before the byte
    always_comb begin
        w_pay              = '0;
        w_pay.kind         = sfp_pkg::KIND_PAYLOAD;
        w_pay.data_byte    = i_byte;
        w_pay.byte_index   = r_pos;
        w_pay.frame_length = r_len;
        w_pay.field_flags  = r_flags;
        w_pay.last         = !w_end_hit;
    end

    // end record from the settled state
    always_comb begin
        w_end              = '0;
        w_end.kind         = sfp_pkg::KIND_END;
        w_end.frame_length = n_len;
        w_end.accepted     = (n_len != 8'd0) && (n_crcok != 8'd0);
        w_end.crc_value    = n_crc;
        w_end.crc_status   = n_crcok;
        w_end.rssi         = n_rssi;
        w_end.lqi          = n_lqi;
        w_end.timestamp    = n_stamp;
        w_end.field_flags  = n_flags;
        w_end.last         = 1'b1;
    end

    assign o_res0 = w_pay_hit ? w_pay : w_end;
    assign o_res1 = w_end;
    assign o_cnt  = {1'b0, w_pay_hit} + {1'b0, w_end_hit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfp_pkg::PH_MAGIC;
            r_pos   <= '0;
            r_flags <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_crcok <= '0;
            r_rssi  <= '0;
            r_lqi   <= '0;
            r_stamp <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_crcok <= n_crcok;
            r_rssi  <= n_rssi;
            r_lqi   <= n_lqi;
            r_stamp <= n_stamp;
        end
    end

    // start byte search never produces a record
    a_magic_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == sfp_pkg::PH_MAGIC) |-> (o_cnt == 2'd0))
        else $error("record produced during start byte search");

    // two records are always a payload byte followed by the end record
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_cnt == 2'd2) |->
        (o_res0.kind == sfp_pkg::KIND_PAYLOAD && o_res1.kind == sfp_pkg::KIND_END))
        else $error("bad record pair");

    // an end record hands over to the start byte search
    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_end_hit) |=> (r_phase == sfp_pkg::PH_MAGIC && r_pos == 8'd0))
        else $error("no restart after end record");

endmodule

// ===== rtl/sfp_rqueue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_rqueue
// small result queue: takes up to two records a cycle, when popped gives one
// ----------------------------------------------------------------------------
module sfp_rqueue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfp_pkg::t_result i_d0,
    input  sfp_pkg::t_result i_d1,
    input  logic [1:0]       i_push_cnt,
    input  logic             i_pop,
    output sfp_pkg::t_result o_head,
    output logic             o_valid,
    output logic             o_room
);

    localparam int AW = sfp_pkg::RQ_AW;
    localparam int CW = sfp_pkg::RQ_AW + 1;

    sfp_pkg::t_result r_mem [sfp_pkg::RQ_DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_count, n_count;
    logic          w_pop;

    assign w_pop   = i_pop && o_valid;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CW'(sfp_pkg::RQ_DEPTH - 2));
    assign o_head  = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp + AW'(i_push_cnt);
        n_rp    = r_rp + AW'(w_pop);
        n_count = r_count + CW'(i_push_cnt) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[AW'(r_wp + 1'b1)] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |->
        ((r_count + CW'(i_push_cnt)) <= CW'(sfp_pkg::RQ_DEPTH)))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_wp - r_rp) == AW'(r_count))
        else $error("queue pointers disagree with count");

endmodule
